// ===== rtl/lda_pkg.sv =====
// Shared types, sizes and helpers of the LDA topic sampler.
`timescale 1ns / 1ps
package lda_pkg;

  localparam int TOPICS = 16;
  localparam int VOCAB = 4096;
  localparam int DOCS = 256;
  localparam int TOKENS = 65536;

  localparam int TOPIC_W = $clog2(TOPICS);
  localparam int KK_W = TOPIC_W + 1;
  localparam int CNT_W = 17;
  localparam int DOC_AW = $clog2(DOCS) + TOPIC_W;
  localparam int WORD_AW = $clog2(VOCAB) + TOPIC_W;
  localparam int SLOT_W = $clog2(TOKENS);
  localparam int CLR_W = WORD_AW;
  localparam int DIVIDEND_W = 50;
  localparam int DIVISOR_W = 38;
  localparam int VB_W = 37;
  localparam int SUM_W = 52;
  localparam int CFG_W = 24;
  localparam int CFG_AW = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [CFG_AW-1:0] {
    REG_ALPHA = 2'd0,
    REG_BETA  = 2'd1,
    REG_VOCAB = 2'd2,
    REG_TOPIC = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_INIT_MUL, ST_INIT_SET, ST_TT_RD, ST_OLD_RD,
    ST_OLD_WR, ST_K_RD, ST_DIV_LD, ST_DIV_WAIT, ST_MUL, ST_ACC, ST_THR_HI, ST_THR_LO,
    ST_THR_SUM, ST_SCAN, ST_NEW_RD, ST_NEW_WR
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_CAPTURE, OP_INIT_MUL, OP_INIT_SET, OP_TT_RD, OP_OLD_RD,
    OP_OLD_WR, OP_K_RD, OP_DIV_LD, OP_MUL, OP_ACC, OP_THR_HI, OP_THR_LO, OP_THR_SUM,
    OP_SCAN, OP_NEW_RD, OP_NEW_WR
  } op_t;

  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic k_last;
    logic hit;
    logic sample;
  } status_t;

  function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
    cnt_inc = (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] cnt_dec(input logic [CNT_W-1:0] c);
    cnt_dec = (c == '0) ? c : c - 1'b1;
  endfunction

endpackage

// ===== rtl/lda_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module lda_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [lda_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [lda_pkg::DIVISOR_W-1:0]    divisor,
  output logic [lda_pkg::DIVIDEND_W-1:0]   quot,
  output logic                             done
);

  localparam int CW = $clog2(lda_pkg::DIVIDEND_W);
  localparam logic [CW-1:0] LAST = CW'(lda_pkg::DIVIDEND_W - 1);

  logic                            run_r, run_nxt;
  logic                            done_r, done_nxt;
  logic [CW-1:0]                   cnt_r, cnt_nxt;
  logic [lda_pkg::DIVIDEND_W-1:0]  q_r, q_nxt;
  logic [lda_pkg::DIVISOR_W-1:0]   rem_r, rem_nxt;
  logic [lda_pkg::DIVISOR_W:0]     shifted, diff;
  logic                            ge;

  assign shifted = {rem_r, q_r[lda_pkg::DIVIDEND_W-1]};
  assign ge = shifted >= {1'b0, divisor};
  assign diff = shifted - {1'b0, divisor};

  always_comb begin
    run_nxt = run_r;
    done_nxt = 1'b0;
    cnt_nxt = cnt_r;
    q_nxt = q_r;
    rem_nxt = rem_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      q_nxt = dividend;
      rem_nxt = '0;
    end else if (run_r) begin
      rem_nxt = ge ? diff[lda_pkg::DIVISOR_W-1:0] : shifted[lda_pkg::DIVISOR_W-1:0];
      q_nxt = {q_r[lda_pkg::DIVIDEND_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        run_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign quot = q_r;
  assign done = done_r;

endmodule

// ===== rtl/lda_dp.sv =====
// Datapath: count memories, configuration, multiplier, divider and accumulation.
`timescale 1ns / 1ps
module lda_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lda_pkg::op_t                 op,
  output lda_pkg::status_t             status,
  input  logic                         cfg_we,
  input  logic [lda_pkg::CFG_AW-1:0]   cfg_index,
  input  logic [lda_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         in_command,
  input  logic [7:0]                   in_doc_index,
  input  logic [15:0]                  in_token_slot,
  input  logic [11:0]                  in_term,
  input  logic [31:0]                  in_uniform,
  output logic                         out_strobe,
  output logic [3:0]                   out_new_topic
);

  localparam int TW = lda_pkg::TOPIC_W;
  localparam int CW = lda_pkg::CNT_W;
  localparam int SW = lda_pkg::SUM_W;

  logic [23:0] alpha_r, beta_r;
  logic [12:0] vocab_r;
  logic [4:0]  topic_cnt_r;

  logic        cmd_r;
  logic [7:0]  d_r;
  logic [15:0] slot_r;
  logic [11:0] w_r;
  logic [31:0] u_r;

  logic [3:0]  tt_mem [0:lda_pkg::TOKENS-1];
  logic [CW-1:0] doc_mem [0:(1 << lda_pkg::DOC_AW)-1];
  logic [CW-1:0] word_mem [0:(1 << lda_pkg::WORD_AW)-1];
  logic [CW-1:0] tot_r [0:lda_pkg::TOPICS-1];

  logic [3:0]    tt_q_r, topic_r;
  logic [CW-1:0] dq_r, wq_r, totq_r;
  logic [63:0]   prod_r;
  logic [lda_pkg::VB_W-1:0] vb_r;
  logic [31:0]   lhs_r;
  logic [SW-1:0] total_r, p1_r, thr_r;
  logic [SW-1:0] cum_r [0:lda_pkg::TOPICS-1];
  logic [TW-1:0] k_r;
  logic [lda_pkg::CLR_W-1:0] clr_r;
  logic          strobe_r;
  logic [3:0]    out_topic_r;

  logic [lda_pkg::KK_W-1:0] kk;
  logic [TW-1:0]  rd_topic;
  logic           cnt_rd, cnt_we;
  logic [CW-1:0]  doc_wd, word_wd, tot_wd;
  logic [lda_pkg::DOC_AW-1:0]  doc_wa;
  logic [lda_pkg::WORD_AW-1:0] word_wa;
  logic [31:0]    mul_a, mul_b, rhs;
  logic           mul_en;
  logic [33:0]    lhs_full, num;
  logic [lda_pkg::DIVISOR_W-1:0]  den;
  logic [lda_pkg::DIVIDEND_W-1:0] quot;
  logic           div_done;
  logic [SW-1:0]  acc_sum;

  always_comb begin
    if (topic_cnt_r == '0) kk = 5'd1;
    else if (topic_cnt_r > 5'(lda_pkg::TOPICS)) kk = 5'(lda_pkg::TOPICS);
    else kk = topic_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= 24'd65536;
      beta_r <= 24'd655;
      vocab_r <= 13'd4096;
      topic_cnt_r <= 5'd16;
    end else if (cfg_we) begin
      case (lda_pkg::reg_idx_t'(cfg_index))
        lda_pkg::REG_ALPHA: alpha_r <= cfg_data;
        lda_pkg::REG_BETA:  beta_r <= cfg_data;
        lda_pkg::REG_VOCAB: vocab_r <= cfg_data[12:0];
        lda_pkg::REG_TOPIC: topic_cnt_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (op == lda_pkg::OP_CAPTURE) begin
      cmd_r <= in_command;
      d_r <= in_doc_index;
      slot_r <= in_token_slot;
      w_r <= in_term;
      u_r <= in_uniform;
    end
  end

  // token topic store, no reset
  always_ff @(posedge clk) begin
    if (op == lda_pkg::OP_NEW_WR) tt_mem[slot_r] <= topic_r;
    if (op == lda_pkg::OP_TT_RD) tt_q_r <= tt_mem[slot_r];
  end

  assign cnt_rd = (op == lda_pkg::OP_OLD_RD) || (op == lda_pkg::OP_K_RD) ||
                  (op == lda_pkg::OP_NEW_RD);
  assign cnt_we = (op == lda_pkg::OP_OLD_WR) || (op == lda_pkg::OP_NEW_WR);

  always_comb begin
    case (op)
      lda_pkg::OP_OLD_RD: rd_topic = tt_q_r;
      lda_pkg::OP_K_RD:   rd_topic = k_r;
      default:            rd_topic = topic_r;
    endcase
  end

  always_comb begin
    if (op == lda_pkg::OP_CLEAR) begin
      doc_wa = clr_r[lda_pkg::DOC_AW-1:0];
      word_wa = clr_r;
      doc_wd = '0;
      word_wd = '0;
    end else begin
      doc_wa = {d_r, topic_r};
      word_wa = {w_r, topic_r};
      doc_wd = (op == lda_pkg::OP_OLD_WR) ? lda_pkg::cnt_dec(dq_r) : lda_pkg::cnt_inc(dq_r);
      word_wd = (op == lda_pkg::OP_OLD_WR) ? lda_pkg::cnt_dec(wq_r) : lda_pkg::cnt_inc(wq_r);
    end
    tot_wd = (op == lda_pkg::OP_OLD_WR) ? lda_pkg::cnt_dec(totq_r) : lda_pkg::cnt_inc(totq_r);
  end

  always_ff @(posedge clk) begin
    if (cnt_we || op == lda_pkg::OP_CLEAR) doc_mem[doc_wa] <= doc_wd;
    if (cnt_rd) dq_r <= doc_mem[{d_r, rd_topic}];
  end

  always_ff @(posedge clk) begin
    if (cnt_we || op == lda_pkg::OP_CLEAR) word_mem[word_wa] <= word_wd;
    if (cnt_rd) wq_r <= word_mem[{w_r, rd_topic}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lda_pkg::TOPICS; i++) tot_r[i] <= '0;
    end else if (cnt_we) begin
      tot_r[topic_r] <= tot_wd;
    end
    if (cnt_rd) totq_r <= tot_r[rd_topic];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (op == lda_pkg::OP_CLEAR) clr_r <= clr_r + 1'b1;
  end

  // shared 32x32 multiplier
  always_comb begin
    mul_en = 1'b1;
    case (op)
      lda_pkg::OP_INIT_MUL: begin mul_a = u_r; mul_b = {27'd0, kk}; end
      lda_pkg::OP_OLD_RD:   begin mul_a = {19'd0, vocab_r}; mul_b = {8'd0, beta_r}; end
      lda_pkg::OP_MUL:      begin mul_a = lhs_r; mul_b = rhs; end
      lda_pkg::OP_THR_HI:   begin mul_a = u_r; mul_b = {12'd0, total_r[SW-1:32]}; end
      lda_pkg::OP_THR_LO:   begin mul_a = u_r; mul_b = total_r[31:0]; end
      default: begin
        mul_en = 1'b0;
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) prod_r <= mul_a * mul_b;
  end

  assign lhs_full = {1'b0, dq_r, 16'd0} + {10'd0, alpha_r};
  assign num = {1'b0, wq_r, 16'd0} + {10'd0, beta_r};
  assign den = {5'd0, totq_r, 16'd0} + {1'b0, vb_r};
  assign rhs = (|quot[lda_pkg::DIVIDEND_W-1:32]) ? 32'hFFFF_FFFF : quot[31:0];
  assign acc_sum = total_r + {4'd0, prod_r[63:16]};

  lda_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (op == lda_pkg::OP_DIV_LD),
    .dividend ({num, 16'd0}),
    .divisor  (den),
    .quot     (quot),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    case (op)
      lda_pkg::OP_OLD_RD: topic_r <= tt_q_r;
      lda_pkg::OP_OLD_WR: begin
        vb_r <= prod_r[lda_pkg::VB_W-1:0];
        k_r <= '0;
        total_r <= '0;
      end
      lda_pkg::OP_DIV_LD: lhs_r <= (|lhs_full[33:32]) ? 32'hFFFF_FFFF : lhs_full[31:0];
      lda_pkg::OP_ACC: begin
        total_r <= acc_sum;
        cum_r[k_r] <= acc_sum;
        k_r <= k_r + 1'b1;
      end
      lda_pkg::OP_THR_LO: p1_r <= prod_r[SW-1:0];
      lda_pkg::OP_THR_SUM: begin
        thr_r <= p1_r + {20'd0, prod_r[63:32]};
        k_r <= '0;
      end
      lda_pkg::OP_SCAN: begin
        if (status.hit) topic_r <= k_r;
        k_r <= k_r + 1'b1;
      end
      lda_pkg::OP_INIT_SET: topic_r <= prod_r[32 +: TW];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) strobe_r <= 1'b0;
    else strobe_r <= (op == lda_pkg::OP_NEW_WR);
    if (op == lda_pkg::OP_NEW_WR) out_topic_r <= topic_r;
  end

  assign status.clr_done = &clr_r;
  assign status.div_done = div_done;
  assign status.k_last = ({1'b0, k_r} == kk - 1'b1);
  assign status.hit = cum_r[k_r] > thr_r;
  assign status.sample = cmd_r;

  assign out_strobe = strobe_r;
  assign out_new_topic = out_topic_r;

endmodule

// ===== rtl/lda_ctrl.sv =====
// Controller state machine of the LDA topic sampler.
`timescale 1ns / 1ps
module lda_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lda_pkg::status_t  status,
  output lda_pkg::op_t      op
);

  lda_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= lda_pkg::ST_CLEAR;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lda_pkg::ST_CLEAR:    if (status.clr_done) state_nxt = lda_pkg::ST_IDLE;
      lda_pkg::ST_IDLE:     if (start) state_nxt = lda_pkg::ST_DISPATCH;
      lda_pkg::ST_DISPATCH: state_nxt = status.sample ? lda_pkg::ST_TT_RD
                                                      : lda_pkg::ST_INIT_MUL;
      lda_pkg::ST_INIT_MUL: state_nxt = lda_pkg::ST_INIT_SET;
      lda_pkg::ST_INIT_SET: state_nxt = lda_pkg::ST_NEW_RD;
      lda_pkg::ST_TT_RD:    state_nxt = lda_pkg::ST_OLD_RD;
      lda_pkg::ST_OLD_RD:   state_nxt = lda_pkg::ST_OLD_WR;
      lda_pkg::ST_OLD_WR:   state_nxt = lda_pkg::ST_K_RD;
      lda_pkg::ST_K_RD:     state_nxt = lda_pkg::ST_DIV_LD;
      lda_pkg::ST_DIV_LD:   state_nxt = lda_pkg::ST_DIV_WAIT;
      lda_pkg::ST_DIV_WAIT: if (status.div_done) state_nxt = lda_pkg::ST_MUL;
      lda_pkg::ST_MUL:      state_nxt = lda_pkg::ST_ACC;
      lda_pkg::ST_ACC:      state_nxt = status.k_last ? lda_pkg::ST_THR_HI : lda_pkg::ST_K_RD;
      lda_pkg::ST_THR_HI:   state_nxt = lda_pkg::ST_THR_LO;
      lda_pkg::ST_THR_LO:   state_nxt = lda_pkg::ST_THR_SUM;
      lda_pkg::ST_THR_SUM:  state_nxt = lda_pkg::ST_SCAN;
      lda_pkg::ST_SCAN:     if (status.hit || status.k_last) state_nxt = lda_pkg::ST_NEW_RD;
      lda_pkg::ST_NEW_RD:   state_nxt = lda_pkg::ST_NEW_WR;
      lda_pkg::ST_NEW_WR:   state_nxt = lda_pkg::ST_IDLE;
      default:              state_nxt = lda_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state_r != lda_pkg::ST_IDLE);
    case (state_r)
      lda_pkg::ST_CLEAR:    op = lda_pkg::OP_CLEAR;
      lda_pkg::ST_IDLE:     op = start ? lda_pkg::OP_CAPTURE : lda_pkg::OP_NONE;
      lda_pkg::ST_INIT_MUL: op = lda_pkg::OP_INIT_MUL;
      lda_pkg::ST_INIT_SET: op = lda_pkg::OP_INIT_SET;
      lda_pkg::ST_TT_RD:    op = lda_pkg::OP_TT_RD;
      lda_pkg::ST_OLD_RD:   op = lda_pkg::OP_OLD_RD;
      lda_pkg::ST_OLD_WR:   op = lda_pkg::OP_OLD_WR;
      lda_pkg::ST_K_RD:     op = lda_pkg::OP_K_RD;
      lda_pkg::ST_DIV_LD:   op = lda_pkg::OP_DIV_LD;
      lda_pkg::ST_MUL:      op = lda_pkg::OP_MUL;
      lda_pkg::ST_ACC:      op = lda_pkg::OP_ACC;
      lda_pkg::ST_THR_HI:   op = lda_pkg::OP_THR_HI;
      lda_pkg::ST_THR_LO:   op = lda_pkg::OP_THR_LO;
      lda_pkg::ST_THR_SUM:  op = lda_pkg::OP_THR_SUM;
      lda_pkg::ST_SCAN:     op = lda_pkg::OP_SCAN;
      lda_pkg::ST_NEW_RD:   op = lda_pkg::OP_NEW_RD;
      lda_pkg::ST_NEW_WR:   op = lda_pkg::OP_NEW_WR;
      default:              op = lda_pkg::OP_NONE;
    endcase
  end

  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lda_pkg::ST_IDLE && start) |=> state_r == lda_pkg::ST_DISPATCH)
    else $error("accepted word not dispatched");

  a_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lda_pkg::ST_DIV_WAIT && status.div_done) |=> state_r == lda_pkg::ST_MUL)
    else $error("divider result not used");

  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lda_pkg::ST_NEW_WR |=> state_r == lda_pkg::ST_IDLE)
    else $error("no return to idle after result");

endmodule

// ===== rtl/lda_gibbs_topic_sampler_top.sv =====
// Top level of the LDA collapsed Gibbs topic sampler.
`timescale 1ns / 1ps
// After reset the block clears its count memories with busy high.
// A word is taken when start is high and busy is low. After that edge busy stays
// high while the new topic is drawn: on a resample the shared bit-serial divider
// runs once per topic, then a scan checks 1 to K topics. The result shows on
// out_strobe for one cycle, the cycle in which busy falls, and must be taken then:
// the receiver cannot stall the block.
module lda_gibbs_topic_sampler_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_command,
  input  logic [7:0]                   in_doc_index,
  input  logic [15:0]                  in_token_slot,
  input  logic [11:0]                  in_term,
  input  logic [31:0]                  in_uniform,
  output logic                         out_strobe,
  output logic [3:0]                   out_new_topic,
  input  logic                         cfg_we,
  input  logic [lda_pkg::CFG_AW-1:0]   cfg_index,
  input  logic [lda_pkg::CFG_W-1:0]    cfg_data
);

  lda_pkg::op_t     op;
  lda_pkg::status_t status;

  lda_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .op     (op)
  );

  lda_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .op            (op),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_command    (in_command),
    .in_doc_index  (in_doc_index),
    .in_token_slot (in_token_slot),
    .in_term       (in_term),
    .in_uniform    (in_uniform),
    .out_strobe    (out_strobe),
    .out_new_topic (out_new_topic)
  );

endmodule

// ===== bench/tb_lda_gibbs_topic_sampler_top.sv =====
// Self-checking testbench of the LDA topic sampler: directed table and corner cases, then random phases.
`timescale 1ns / 1ps
module tb_lda_gibbs_topic_sampler_top;

  localparam logic CMD_INIT = 1'b0;
  localparam logic CMD_RESAMPLE = 1'b1;
  localparam longint unsigned Q32_LIM = 64'hFFFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_command = 1'b0;
  logic [7:0] in_doc_index = '0;
  logic [15:0] in_token_slot = '0;
  logic [11:0] in_term = '0;
  logic [31:0] in_uniform = '0;
  logic out_strobe;
  logic [3:0] out_new_topic;
  logic cfg_we = 1'b0;
  logic [lda_pkg::CFG_AW-1:0] cfg_index = '0;
  logic [lda_pkg::CFG_W-1:0] cfg_data = '0;

  lda_gibbs_topic_sampler_top uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #60_000_000;
    $display("FAIL");
    $finish;
  end

  // sampler state mirror
  bit [23:0] alpha_m, beta_m;
  bit [12:0] vocab_m;
  bit [4:0] ktopics_m;
  bit [16:0] doc_cnt[lda_pkg::DOCS*lda_pkg::TOPICS];
  bit [16:0] word_cnt[lda_pkg::VOCAB*lda_pkg::TOPICS];
  bit [16:0] topic_tot[lda_pkg::TOPICS];
  bit [3:0] slot_topic[lda_pkg::TOKENS];
  bit slot_known[int];
  int written_slots[$];
  logic [3:0] topic_q[$];
  int errors = 0;

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic void tally(int d, int w, int t, bit add);
    int a, b;
    a = d * lda_pkg::TOPICS + t;
    b = w * lda_pkg::TOPICS + t;
    if (add) begin
      if (doc_cnt[a] != '1) doc_cnt[a]++;
      if (word_cnt[b] != '1) word_cnt[b]++;
      if (topic_tot[t] != '1) topic_tot[t]++;
    end else begin
      if (doc_cnt[a] != 0) doc_cnt[a]--;
      if (word_cnt[b] != 0) word_cnt[b]--;
      if (topic_tot[t] != 0) topic_tot[t]--;
    end
  endfunction

  function automatic bit [3:0] draw_topic(bit cmd, int d, int slot, int w, bit [31:0] u);
    longint unsigned cum[lda_pkg::TOPICS];
    longint unsigned vb, total, thr, lhs, num, den, rhs;
    int kk, topic;
    kk = (ktopics_m == 0) ? 1 : (ktopics_m > lda_pkg::TOPICS ? lda_pkg::TOPICS : ktopics_m);
    if (cmd == CMD_INIT) begin
      topic = int'((longint'(u) * kk) >> 32);
    end else begin
      topic = slot_topic[slot];
      tally(d, w, topic, 0);
      vb = longint'(vocab_m) * beta_m;
      total = 0;
      for (int k = 0; k < kk; k++) begin
        lhs = (longint'(doc_cnt[d*lda_pkg::TOPICS+k]) << 16) + alpha_m;
        num = (longint'(word_cnt[w*lda_pkg::TOPICS+k]) << 16) + beta_m;
        den = (longint'(topic_tot[k]) << 16) + vb;
        if (lhs > Q32_LIM) lhs = Q32_LIM;
        if (den == 0) rhs = Q32_LIM;
        else begin
          rhs = (num << 16) / den;
          if (rhs > Q32_LIM) rhs = Q32_LIM;
        end
        total += (lhs * rhs) >> 16;
        cum[k] = total;
      end
      thr = longint'(u) * (total >> 32) + ((longint'(u) * (total & Q32_LIM)) >> 32);
      for (int k = 0; k < kk; k++) begin
        if (cum[k] > thr) begin
          topic = k;
          break;
        end
      end
    end
    tally(d, w, topic, 1);
    slot_topic[slot] = 4'(topic);
    if (!slot_known.exists(slot)) begin
      slot_known[slot] = 1;
      written_slots.push_back(slot);
    end
    return 4'(topic);
  endfunction

  task automatic write_reg(input lda_pkg::reg_idx_t idx, input logic [lda_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      lda_pkg::REG_ALPHA: alpha_m = val;
      lda_pkg::REG_BETA: beta_m = val;
      lda_pkg::REG_VOCAB: vocab_m = val[12:0];
      lda_pkg::REG_TOPIC: ktopics_m = val[4:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_word(input bit cmd, input int d, input int slot, input int w,
                           input bit [31:0] u, input int want);
    bit [3:0] t;
    in_command <= cmd;
    in_doc_index <= 8'(d);
    in_token_slot <= 16'(slot);
    in_term <= 12'(w);
    in_uniform <= u;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    t = draw_topic(cmd, d, slot, w, u);
    if (want >= 0 && t != want) report($sformatf("table row slot %0d predicted %0d, want %0d",
                                                 slot, t, want));
    topic_q.push_back(t);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (topic_q.size() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (topic_q.size() == 0) report("result word with nothing expected");
      else begin
        logic [3:0] e;
        e = topic_q.pop_front();
        if (out_new_topic !== e)
          report($sformatf("new_topic %0d, expected %0d", out_new_topic, e));
      end
    end
  end

  typedef struct {
    bit cmd;
    int d, slot, w;
    bit [31:0] u;
    int want;
  } row_t;

  row_t dir_rows[] = '{
    '{CMD_INIT, 0, 0, 0, 32'h0000_0000, 0},
    '{CMD_INIT, 255, 65535, 4095, 32'hFFFF_FFFF, 15},
    '{CMD_INIT, 1, 1, 1, 32'h8000_0000, 8},
    '{CMD_INIT, 1, 2, 1, 32'h8000_0000, 8},
    '{CMD_RESAMPLE, 0, 0, 0, 32'h0000_0000, -1},
    '{CMD_RESAMPLE, 255, 65535, 4095, 32'hFFFF_FFFF, -1},
    '{CMD_RESAMPLE, 1, 1, 1, 32'h5555_5555, -1},
    '{CMD_RESAMPLE, 1, 2, 1, 32'hAAAA_AAAA, -1},
    '{CMD_INIT, 1, 1, 1, 32'h0000_0000, 0},
    '{CMD_RESAMPLE, 1, 1, 1, 32'h7FFF_FFFF, -1},
    '{CMD_RESAMPLE, 170, 65535, 2730, 32'h1234_5678, -1}
  };

  int gap, phase_items;
  bit [31:0] ru;

  initial begin
    alpha_m = 24'd65536;
    beta_m = 24'd655;
    vocab_m = 13'd4096;
    ktopics_m = 5'd16;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    foreach (dir_rows[i])
      send_word(dir_rows[i].cmd, dir_rows[i].d, dir_rows[i].slot, dir_rows[i].w,
                dir_rows[i].u, dir_rows[i].want);
    settle();
    // zero weights everywhere: old topic kept; zero denominator with beta 0
    write_reg(lda_pkg::REG_ALPHA, 24'd0);
    write_reg(lda_pkg::REG_BETA, 24'd0);
    send_word(CMD_INIT, 200, 500, 3000, 32'hC000_0000, 12);
    send_word(CMD_RESAMPLE, 200, 500, 3000, 32'h0, -1);
    send_word(CMD_RESAMPLE, 200, 500, 3000, 32'hFFFF_FFFF, -1);
    settle();
    // topic count zero acts as one, above range acts as sixteen
    write_reg(lda_pkg::REG_TOPIC, 24'd0);
    write_reg(lda_pkg::REG_ALPHA, 24'hFFFFFF);
    write_reg(lda_pkg::REG_BETA, 24'hFFFFFF);
    write_reg(lda_pkg::REG_VOCAB, 24'd0);
    send_word(CMD_INIT, 3, 7, 9, 32'hFFFF_FFFF, 0);
    send_word(CMD_RESAMPLE, 255, 65535, 4095, 32'h9999_9999, -1);
    settle();
    write_reg(lda_pkg::REG_TOPIC, 24'hFFFFFF);
    send_word(CMD_INIT, 3, 8, 9, 32'hFFFF_FFFF, 15);
    send_word(CMD_RESAMPLE, 3, 8, 9, 32'h0, -1);
    settle();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          write_reg(lda_pkg::REG_ALPHA, 24'd65536); write_reg(lda_pkg::REG_BETA, 24'd655);
          write_reg(lda_pkg::REG_VOCAB, 24'd4096);  write_reg(lda_pkg::REG_TOPIC, 24'd16);
        end
        1: begin
          write_reg(lda_pkg::REG_ALPHA, 24'd1);     write_reg(lda_pkg::REG_BETA, 24'd1);
          write_reg(lda_pkg::REG_VOCAB, 24'd1);     write_reg(lda_pkg::REG_TOPIC, 24'd1);
        end
        2: begin
          write_reg(lda_pkg::REG_ALPHA, 24'hFFFFFF); write_reg(lda_pkg::REG_BETA, 24'hFFFFFF);
          write_reg(lda_pkg::REG_VOCAB, 24'h1FFF);   write_reg(lda_pkg::REG_TOPIC, 24'd5);
        end
        3: begin
          write_reg(lda_pkg::REG_ALPHA, 24'd0);     write_reg(lda_pkg::REG_BETA, 24'd3);
          write_reg(lda_pkg::REG_VOCAB, 24'd2);     write_reg(lda_pkg::REG_TOPIC, 24'd2);
        end
        default: begin
          write_reg(lda_pkg::REG_ALPHA,
                    24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 20)));
          write_reg(lda_pkg::REG_BETA,
                    24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 20)));
          write_reg(lda_pkg::REG_VOCAB, 24'($urandom_range(1, 4096)));
          write_reg(lda_pkg::REG_TOPIC, 24'($urandom_range(0, 31)));
        end
      endcase
      phase_items = 150;
      for (int n = 0; n < phase_items; n++) begin
        int d, w, slot;
        ru = $urandom();
        if ($urandom_range(0, 9) == 0) begin
          d = $urandom_range(0, 255);
          w = $urandom_range(0, 4095);
        end else begin
          d = $urandom_range(0, 3);
          w = $urandom_range(0, 7);
        end
        if (written_slots.size() != 0 && $urandom_range(0, 9) < 7) begin
          slot = written_slots[$urandom_range(0, written_slots.size() - 1)];
          send_word(CMD_RESAMPLE, d, slot, w, ru, -1);
        end else begin
          slot = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                             : $urandom_range(0, 63);
          send_word(CMD_INIT, d, slot, w, ru, -1);
        end
        if (ph < 6 && $urandom_range(0, 2) == 0) begin
          gap = $urandom_range(1, 12);
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      settle();
    end

    repeat (200) @(posedge clk);
    if (errors == 0 && topic_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
